// File: rtl/core/ptw_pkg.sv
package ptw_pkg;

    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned ENTRIES = 512;

    localparam logic [31:0] PTR_MASK   = 32'hFFFF_F000;
    localparam logic [51:0] FRAME_MASK = 52'hF_FFFF_FFFF_F000;
    localparam logic [63:0] BIT_PRESENT = 64'h1;
    localparam logic [63:0] BIT_WRITE   = 64'h2;
    localparam logic [63:0] BIT_PWT     = 64'h8;
    localparam logic [63:0] BIT_PAT     = 64'h80;
    localparam logic [63:0] BIT_GLOBAL  = 64'h100;
    localparam logic [63:0] BIT_NX      = 64'h8000_0000_0000_0000;

    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_MAP  = 2'd1;
    localparam logic [1:0] ST_ALREADY  = 2'd2;
    localparam logic [1:0] ST_NO_TABLE = 2'd3;

    typedef enum logic [2:0] {
        S_CLR_ROOT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_LINK,
        S_LEAF,
        S_OUT
    } walk_state_t;

endpackage

// File: rtl/core/ptw_ram.sv
module ptw_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/ptw_walk.sv
module ptw_walk #(
    parameter int unsigned NUM_TABLES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [47:0] virt_addr,
    input  logic [51:0] phys_addr,
    input  logic        flag_write,
    input  logic        flag_execute,
    input  logic        flag_global,
    input  logic        write_combine,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [51:0] frame_addr,
    output logic [1:0]  status
);

    localparam int unsigned TW = $clog2(NUM_TABLES);
    localparam int unsigned CW = $clog2(NUM_TABLES + 1);
    localparam int unsigned AW = TW + ptw_pkg::IDX_W;

    ptw_pkg::walk_state_t state_reg, state_next;

    logic [31:0]  base_reg;
    logic [CW-1:0] free_reg, free_next;
    logic [1:0]   lvl_reg, lvl_next;
    logic [TW-1:0] tab_reg, tab_next;
    logic [TW-1:0] new_reg, new_next;
    logic [ptw_pkg::IDX_W-1:0] clr_reg, clr_next;
    logic         type_reg;
    logic [35:0]  va_reg;
    logic [63:0]  leaf_reg;
    logic [51:0]  frame_reg, frame_next;
    logic [1:0]   status_reg, status_next;
    logic         rv_reg, rv_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    logic [ptw_pkg::IDX_W-1:0] cur_ix;
    logic [31:0] off;
    logic        dangle;
    logic [CW:0] need;
    logic [31:0] ptr;

    ptw_ram #(.WIDTH(ptw_pkg::ENTRY_W), .DEPTH(NUM_TABLES * ptw_pkg::ENTRIES)) u_ram (
        .aclk (aclk), .we (we), .waddr (waddr), .wdata (wdata),
        .raddr (raddr), .rdata (rdata)
    );

    // index of the level being walked
    always_comb begin
        case (lvl_reg)
            2'd0:    cur_ix = va_reg[35:27];
            2'd1:    cur_ix = va_reg[26:18];
            2'd2:    cur_ix = va_reg[17:9];
            default: cur_ix = va_reg[8:0];
        endcase
    end

    // pointer decode
    assign off    = ((rdata[31:0] & ptw_pkg::PTR_MASK) - (base_reg & ptw_pkg::PTR_MASK)) >> 12;
    assign dangle = off >= 32'(NUM_TABLES);
    assign need   = (CW + 1)'(free_reg) + (CW + 1)'(3 - lvl_reg);
    assign ptr    = ((base_reg & ptw_pkg::PTR_MASK) + (32'(new_reg) << 12))
                    & ptw_pkg::PTR_MASK;
    assign raddr  = {tab_reg, cur_ix};

    always_comb begin
        state_next  = state_reg;
        free_next   = free_reg;
        lvl_next    = lvl_reg;
        tab_next    = tab_reg;
        new_next    = new_reg;
        clr_next    = clr_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        we          = 1'b0;
        waddr       = {tab_reg, cur_ix};
        wdata       = '0;
        req_ready   = 1'b0;
        if (res_ready) begin
            rv_next = 1'b0;
        end
        unique case (state_reg)
            ptw_pkg::S_CLR_ROOT: begin
                // clear the root table after reset
                we       = 1'b1;
                waddr    = {TW'(0), clr_reg};
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ptw_pkg::S_IDLE;
                end
            end
            ptw_pkg::S_IDLE: begin
                req_ready = !rv_reg || res_ready;
                lvl_next  = '0;
                tab_next  = '0;
                if (req_valid && req_ready) begin
                    state_next = ptw_pkg::S_READ;
                end
            end
            ptw_pkg::S_READ: begin
                state_next = ptw_pkg::S_CHECK;
            end
            ptw_pkg::S_CHECK: begin
                frame_next  = '0;
                status_next = ptw_pkg::ST_OK;
                state_next  = ptw_pkg::S_OUT;
                if (lvl_reg == 2'd3) begin
                    if (type_reg == ptw_pkg::REQ_LOOKUP) begin
                        if (rdata[0]) begin
                            frame_next = rdata[51:0] & ptw_pkg::FRAME_MASK;
                        end else begin
                            status_next = ptw_pkg::ST_NOT_MAP;
                        end
                    end else if (rdata[0]) begin
                        status_next = ptw_pkg::ST_ALREADY;
                    end else begin
                        state_next = ptw_pkg::S_LEAF;
                    end
                end else if (rdata[0] && !dangle) begin
                    tab_next   = TW'(off);
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = ptw_pkg::S_READ;
                end else if (type_reg == ptw_pkg::REQ_LOOKUP) begin
                    status_next = ptw_pkg::ST_NOT_MAP;
                end else if (rdata[0] || need > (CW + 1)'(NUM_TABLES)) begin
                    status_next = ptw_pkg::ST_NO_TABLE;
                end else begin
                    new_next   = TW'(free_reg);
                    free_next  = free_reg + 1'b1;
                    clr_next   = '0;
                    state_next = ptw_pkg::S_CLEAR;
                end
            end
            ptw_pkg::S_CLEAR: begin
                // zero the new table one entry a cycle
                we       = 1'b1;
                waddr    = {new_reg, clr_reg};
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ptw_pkg::S_LINK;
                end
            end
            ptw_pkg::S_LINK: begin
                we    = 1'b1;
                wdata = {32'd0, ptr} | ptw_pkg::BIT_PRESENT | ptw_pkg::BIT_WRITE;
                if (lvl_reg == 2'd2) begin
                    state_next = ptw_pkg::S_LEAF;
                end else begin
                    new_next  = TW'(free_reg);
                    free_next = free_reg + 1'b1;
                    clr_next  = '0;
                    state_next = ptw_pkg::S_CLEAR;
                end
                tab_next = new_reg;
                lvl_next = lvl_reg + 1'b1;
            end
            ptw_pkg::S_LEAF: begin
                we          = 1'b1;
                wdata       = leaf_reg;
                frame_next  = '0;
                status_next = ptw_pkg::ST_OK;
                state_next  = ptw_pkg::S_OUT;
            end
            ptw_pkg::S_OUT: begin
                if (!rv_reg || res_ready) begin
                    rv_next    = 1'b1;
                    state_next = ptw_pkg::S_IDLE;
                end
            end
            default: state_next = ptw_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptw_pkg::S_CLR_ROOT;
            free_reg  <= CW'(1);
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
            base_reg  <= 32'd1048576;
            lvl_reg   <= '0;
            tab_reg   <= '0;
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            lvl_reg   <= lvl_next;
            tab_reg   <= tab_next;
            if (cfg_we) begin
                base_reg <= cfg_wdata;
            end
        end
    end

    // request payload and result
    always_ff @(posedge aclk) begin
        new_reg    <= new_next;
        frame_reg  <= frame_next;
        status_reg <= status_next;
        if (req_valid && req_ready) begin
            type_reg <= req_type;
            va_reg   <= virt_addr[47:12];
            leaf_reg <= {12'd0, phys_addr & ptw_pkg::FRAME_MASK} | ptw_pkg::BIT_PRESENT
                      | (flag_write ? ptw_pkg::BIT_WRITE : 64'd0)
                      | (flag_execute ? 64'd0 : ptw_pkg::BIT_NX)
                      | (flag_global ? ptw_pkg::BIT_GLOBAL : 64'd0)
                      | (write_combine ? (ptw_pkg::BIT_PAT | ptw_pkg::BIT_PWT) : 64'd0);
        end
    end

    assign res_valid  = rv_reg;
    assign frame_addr = frame_reg;
    assign status     = status_reg;

endmodule

// File: rtl/core/four_level_page_table_walker_top.sv
// channel | bits                     | contents
// s_axis  | tuser[0], tdata[103:0]   | request: type in tuser; virtual address, frame, flags
// m_axis  | tdata[55:0]              | result: frame address, status
// cfg     | 32                       | table base, write only
// a lookup gives its result after a read state and a check state per level
// walked, then the result register.
// a map adds a leaf write, plus a clear of all 512 entries and a link write per
// table it allocates.
// after reset the root table's 512 entries are cleared; no request is taken then.
// a result waiting on m_axis_tready holds the walker before the next request.
module four_level_page_table_walker_top #(
    parameter int unsigned NUM_TABLES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[0]
    input  logic         s_axis_tuser,
    // virt_addr[47:0], phys_addr[99:48], flag_write[100], flag_execute[101],
    // flag_global[102], write_combine[103]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_addr[51:0], status[53:52], zero pad
    output logic [55:0]  m_axis_tdata
);

    logic [51:0] frame_addr;
    logic [1:0]  status;

    ptw_walk #(.NUM_TABLES(NUM_TABLES)) u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (s_axis_tvalid),
        .req_ready     (s_axis_tready),
        .req_type      (s_axis_tuser),
        .virt_addr     (s_axis_tdata[47:0]),
        .phys_addr     (s_axis_tdata[99:48]),
        .flag_write    (s_axis_tdata[100]),
        .flag_execute  (s_axis_tdata[101]),
        .flag_global   (s_axis_tdata[102]),
        .write_combine (s_axis_tdata[103]),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .frame_addr    (frame_addr),
        .status        (status)
    );

    assign m_axis_tdata = {2'b00, status, frame_addr};

endmodule

// File: rtl/core/ptw_checker.sv
module ptw_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata
);

    // result stalls hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // frame is zero unless status ok
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[53:52] != 2'd0 |-> m_axis_tdata[51:0] == 52'd0)
        else $error("frame on failed request");

    // padding stays zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[55:54] == 2'b00)
        else $error("result padding set");

    // no request taken in the cycle right after one was accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted twice in a row");

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
